### design/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the PID position controller: sequencer
// states, register indexes, serial unit widths and step counts.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    // register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_GAIN_P        = 3'd0;
    localparam logic [2:0] REG_GAIN_I        = 3'd1;
    localparam logic [2:0] REG_GAIN_D        = 3'd2;
    localparam logic [2:0] REG_UPPER_LIMIT   = 3'd3;
    localparam logic [2:0] REG_LOWER_LIMIT   = 3'd4;
    localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd5;
    localparam logic [2:0] REG_DEADBAND      = 3'd6;
    localparam logic [2:0] REG_POS_OFFSET    = 3'd7;

    localparam logic [15:0] DEADBAND_RESET   = 16'd2;

    // shift-add multiplier: operand width, one multiplier bit per step
    localparam int MUL_W       = 41;
    localparam int MUL_STEPS   = MUL_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);
    localparam int ACC_W       = 60;
    localparam int CAP_BIT     = 40;
    localparam logic [ACC_W-1:0] INC_CAP =
        {{(ACC_W-CAP_BIT-1){1'b0}}, 1'b1, {CAP_BIT{1'b0}}};

    // restoring divider: one quotient bit per step
    localparam int DIV_N       = 57;
    localparam int DIV_D       = 32;
    localparam int DIV_STEPS   = DIV_N;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic start;
        logic sat_en;
    } mul_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MAG,
        S_DB,
        S_MUL1,
        S_START2,
        S_WAIT2,
        S_INT,
        S_SUM,
        S_CLAMP,
        S_DRIVE,
        S_DONE
    } pidc_state_t;

endpackage

`default_nettype wire

### design/pid_position_controller.sv
// ----------------------------------------------------------------------------
// pid_position_controller
// PID position loop with deadband, clamped integral and minimum drive floor.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  target, position, now_ms
//   output    out        out_valid/out_stall  drive, in_deadband
//   config    in         APB write / read     pwdata / prdata, paddr[4:2]
//
// An active step first runs the three serial products side by side
// (proportional, derivative numerator, integral gain times error), then
// the divide by elapsed time, running beside the second integral product.
// A deadband step skips the products. Reset clears the loop state and the
// registers (deadband to 2). A new transfer is taken in the idle state even
// while a finished result waits in the output register under out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] target,
    input  logic signed [31:0] position,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] drive,
    output logic               in_deadband
);
    import pidc_pkg::*;

    // configuration
    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [9:0]  upper_reg, floor_reg;
    logic [10:0] lower_reg;
    logic [15:0] deadband_reg;
    logic [31:0] offset_reg;
    logic        cfg_wr;

    // loop state
    logic [31:0] integral_reg;
    logic [32:0] prev_err_reg;
    logic [31:0] last_time_reg;

    // sequencer and datapath
    pidc_state_t state_reg, state_next;
    logic [31:0] tgt_reg, pos_reg, now_reg;
    logic [32:0] err_reg;
    logic [32:0] emag_reg;
    logic        eneg_reg;
    logic [33:0] dmag_reg;
    logic        dneg_reg;
    logic [31:0] dt_reg;
    logic        db_flag_reg;
    logic [31:0] isum_reg;
    logic signed [ACC_W-1:0] pterm_reg, dterm_reg, sum_reg;
    logic signed [27:0] clamp_reg;
    logic        pos_flag_reg;
    logic [11:0] res_drive_reg;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] drive_reg;
    logic        inband_reg;
    logic        out_load;

    // combinational datapath
    logic [33:0] raw_err;
    logic [32:0] err_sat;
    logic [33:0] diff;
    logic [31:0] dt_raw;
    logic signed [42:0] isum_wide, hi43, lo43;
    logic [31:0] isum_clamped;
    logic signed [ACC_W-1:0] sum_wide, hi60, lo60;
    logic signed [27:0] clamp_val, clamp_neg;
    logic [11:0] trunc_val;

    // serial units
    mul_cmd_t           mp_cmd, mi_cmd, md_cmd;
    logic [MUL_W-1:0]   mi_a;
    logic               mp_done, mi_done, md_done;
    logic [ACC_W-1:0]   mp_prod, mi_prod, md_prod;
    logic               div_start, div_done;
    logic [DIV_N-1:0]   div_quot;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            upper_reg    <= '0;
            lower_reg    <= '0;
            floor_reg    <= '0;
            deadband_reg <= DEADBAND_RESET;
            offset_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_GAIN_P:      gain_p_reg   <= pwdata[23:0];
                REG_GAIN_I:      gain_i_reg   <= pwdata[23:0];
                REG_GAIN_D:      gain_d_reg   <= pwdata[23:0];
                REG_UPPER_LIMIT: upper_reg    <= pwdata[9:0];
                REG_LOWER_LIMIT: lower_reg    <= pwdata[10:0];
                REG_DRIVE_FLOOR: floor_reg    <= pwdata[9:0];
                REG_DEADBAND:    deadband_reg <= pwdata[15:0];
                REG_POS_OFFSET:  offset_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_GAIN_P:      prdata = {8'd0, gain_p_reg};
            REG_GAIN_I:      prdata = {8'd0, gain_i_reg};
            REG_GAIN_D:      prdata = {8'd0, gain_d_reg};
            REG_UPPER_LIMIT: prdata = {22'd0, upper_reg};
            REG_LOWER_LIMIT: prdata = {{21{lower_reg[10]}}, lower_reg};
            REG_DRIVE_FLOOR: prdata = {22'd0, floor_reg};
            REG_DEADBAND:    prdata = {16'd0, deadband_reg};
            REG_POS_OFFSET:  prdata = offset_reg;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // serial units
    // ------------------------------------------------------------------
    pidc_mul u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mp_cmd),
        .a     ({{(MUL_W-24){1'b0}}, gain_p_reg}),
        .b     ({{(MUL_W-33){1'b0}}, emag_reg}),
        .done  (mp_done),
        .prod  (mp_prod)
    );

    pidc_mul u_mul_i (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mi_cmd),
        .a     (mi_a),
        .b     ((state_reg == S_START2) ? {{(MUL_W-32){1'b0}}, dt_reg}
                                        : {{(MUL_W-33){1'b0}}, emag_reg}),
        .done  (mi_done),
        .prod  (mi_prod)
    );

    pidc_mul u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (md_cmd),
        .a     ({{(MUL_W-24){1'b0}}, gain_d_reg}),
        .b     ({{(MUL_W-34){1'b0}}, dmag_reg}),
        .done  (md_done),
        .prod  (md_prod)
    );

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (md_prod[DIV_N-1:0]),
        .divisor  (dt_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign mi_a = (state_reg == S_START2) ? mi_prod[MUL_W-1:0]
                                          : {{(MUL_W-24){1'b0}}, gain_i_reg};

    // ------------------------------------------------------------------
    // datapath arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        raw_err = {{2{tgt_reg[31]}}, tgt_reg} + {{2{offset_reg[31]}}, offset_reg}
                - {{2{pos_reg[31]}}, pos_reg};
        if (raw_err[33] != raw_err[32])
        begin
            err_sat = raw_err[33] ? {1'b1, 32'd0} : {1'b0, {32{1'b1}}};
        end
        else
        begin
            err_sat = raw_err[32:0];
        end

        diff   = {err_reg[32], err_reg} - {prev_err_reg[32], prev_err_reg};
        dt_raw = now_reg - last_time_reg;

        hi43 = {17'd0, upper_reg, 16'd0};
        lo43 = {{16{lower_reg[10]}}, lower_reg, 16'd0};
        isum_wide = {{11{integral_reg[31]}}, integral_reg}
                  + (eneg_reg ? -{2'b00, mi_prod[40:0]} : {2'b00, mi_prod[40:0]});
        if (isum_wide > hi43)
        begin
            isum_clamped = hi43[31:0];
        end
        else if (isum_wide < lo43)
        begin
            isum_clamped = lo43[31:0];
        end
        else
        begin
            isum_clamped = isum_wide[31:0];
        end

        hi60 = {{(ACC_W-26){1'b0}}, upper_reg, 16'd0};
        lo60 = {{(ACC_W-27){lower_reg[10]}}, lower_reg, 16'd0};
        sum_wide = pterm_reg + {{(ACC_W-32){isum_reg[31]}}, isum_reg} - dterm_reg;
        if (sum_reg > 0)
        begin
            clamp_val = (sum_reg > hi60) ? hi60[27:0] : sum_reg[27:0];
        end
        else
        begin
            clamp_val = (sum_reg < lo60) ? lo60[27:0] : sum_reg[27:0];
        end

        clamp_neg = -clamp_reg;
        trunc_val = clamp_reg[27] ? -clamp_neg[27:16] : clamp_reg[27:16];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_DRIVE)
            begin
                integral_reg  <= isum_reg;
                prev_err_reg  <= err_reg;
                last_time_reg <= now_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mp_cmd     = '0;
        mi_cmd     = '0;
        md_cmd     = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:    state_next = S_MAG;
            S_MAG:    state_next = S_DB;
            S_DB:
            begin
                if (emag_reg < {17'd0, deadband_reg})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mp_cmd     = '{start: 1'b1, sat_en: 1'b0};
                    mi_cmd     = '{start: 1'b1, sat_en: 1'b1};
                    md_cmd     = '{start: 1'b1, sat_en: 1'b0};
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (mp_done && mi_done && md_done)
                begin
                    state_next = S_START2;
                end
            end
            S_START2:
            begin
                mi_cmd     = '{start: 1'b1, sat_en: 1'b1};
                div_start  = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (div_done)
                begin
                    state_next = S_INT;
                end
            end
            S_INT:    state_next = S_SUM;
            S_SUM:    state_next = S_CLAMP;
            S_CLAMP:  state_next = S_DRIVE;
            S_DRIVE:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tgt_reg <= target;
                pos_reg <= position;
                now_reg <= now_ms;
            end
            S_ERR:
            begin
                err_reg <= err_sat;
            end
            S_MAG:
            begin
                eneg_reg <= err_reg[32];
                emag_reg <= err_reg[32] ? (~err_reg + 33'd1) : err_reg;
                dneg_reg <= diff[33];
                dmag_reg <= diff[33] ? (~diff + 34'd1) : diff;
                dt_reg   <= (dt_raw == 32'd0) ? 32'd1 : dt_raw;
            end
            S_DB:
            begin
                db_flag_reg <= (emag_reg < {17'd0, deadband_reg});
            end
            S_INT:
            begin
                isum_reg  <= isum_clamped;
                pterm_reg <= eneg_reg ? -mp_prod : mp_prod;
                dterm_reg <= dneg_reg ? -{{(ACC_W-DIV_N){1'b0}}, div_quot}
                                      : {{(ACC_W-DIV_N){1'b0}}, div_quot};
            end
            S_SUM:
            begin
                sum_reg <= sum_wide;
            end
            S_CLAMP:
            begin
                clamp_reg    <= clamp_val;
                pos_flag_reg <= (sum_reg > 0);
            end
            S_DRIVE:
            begin
                res_drive_reg <= pos_flag_reg ? (trunc_val + {2'b00, floor_reg})
                                              : (trunc_val - {2'b00, floor_reg});
            end
            default: ;
        endcase

        if (out_load)
        begin
            drive_reg  <= db_flag_reg ? 12'd0 : res_drive_reg;
            inband_reg <= db_flag_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign in_deadband = inband_reg;

endmodule

`default_nettype wire

### design/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Serial shift-add multiplier, multiplier bits taken MSB first, one per
// cycle. Optional sticky saturation of the product at the integral cap.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidc_pkg::mul_cmd_t            cmd,
    input  logic [pidc_pkg::MUL_W-1:0]    a,
    input  logic [pidc_pkg::MUL_W-1:0]    b,
    output logic                          done,
    output logic [pidc_pkg::ACC_W-1:0]    prod
);
    import pidc_pkg::*;

    logic                 busy_reg, busy_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 sat_reg, sat_next;
    logic                 sat_en_reg;
    logic [MUL_W-1:0]     a_reg;
    logic [MUL_W-1:0]     b_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     step_sum;

    always_comb
    begin
        step_sum  = {acc_reg[ACC_W-2:0], 1'b0}
                  + (b_reg[MUL_W-1] ? {{(ACC_W-MUL_W){1'b0}}, a_reg} : '0);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_W'(MUL_STEPS);
            sat_next  = 1'b0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
            if (!sat_reg)
            begin
                acc_next = step_sum;
                if (sat_en_reg && (step_sum > INC_CAP))
                begin
                    sat_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            sat_reg  <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.start)
        begin
            a_reg      <= a;
            b_reg      <= b;
            sat_en_reg <= cmd.sat_en;
        end
        else if (busy_reg)
        begin
            b_reg <= {b_reg[MUL_W-2:0], 1'b0};
        end
    end

    assign done = busy_reg && (cnt_reg == MUL_CNT_W'(1));
    assign prod = sat_reg ? INC_CAP : acc_reg;

endmodule

`default_nettype wire

### design/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Serial restoring divider, unsigned, one quotient bit per cycle. The
// dividend register shifts out numerator bits and takes quotient bits in.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pidc_pkg::DIV_N-1:0]    dividend,
    input  logic [pidc_pkg::DIV_D-1:0]    divisor,
    output logic                          done,
    output logic [pidc_pkg::DIV_N-1:0]    quot
);
    import pidc_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N-1:0]     num_reg;
    logic [DIV_D-1:0]     den_reg;
    logic [DIV_D-1:0]     rem_reg;
    logic [DIV_D:0]       trial;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_N-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_N-2:0], fits};
            rem_reg <= fits ? DIV_D'(trial - {1'b0, den_reg}) : trial[DIV_D-1:0];
        end
    end

    assign done = busy_reg && (cnt_reg == DIV_CNT_W'(1));
    assign quot = num_reg;

endmodule

`default_nettype wire

### tb/sv/pid_position_controller_test.sv
// ----------------------------------------------------------------------------
// pid_position_controller_test
// Self-checking regression for the PID position controller. A scoreboard
// class predicts drive and deadband flag for each accepted control step
// from its own copy of the gains, limits and loop state. Plain tasks drive
// the APB port and the step channel. Step inputs see random idle gaps, the
// output random stall cycles. A directed pass covers the deadband edges,
// error saturation, zero and wrapped elapsed time and the limit extremes.
// Randomised phases then follow, each with fresh register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int QUIET_PHASE     = 5;

    typedef struct packed {
        logic signed [11:0] drive;
        logic               in_deadband;
    } drive_result_t;

    class drive_scoreboard;
        longint gain_p, gain_i, gain_d;
        longint upper_limit, lower_limit, floor_level, band, offset;
        longint integral, last_error;
        logic [31:0] last_time;
        drive_result_t pending_drives[$];
        int failures;

        function new();
            gain_p      = 0;
            gain_i      = 0;
            gain_d      = 0;
            upper_limit = 0;
            lower_limit = 0;
            floor_level = 0;
            band        = longint'(DEADBAND_RESET);
            offset      = 0;
            integral    = 0;
            last_error  = 0;
            last_time   = '0;
            failures    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_GAIN_P:      gain_p      = longint'(value[23:0]);
                REG_GAIN_I:      gain_i      = longint'(value[23:0]);
                REG_GAIN_D:      gain_d      = longint'(value[23:0]);
                REG_UPPER_LIMIT: upper_limit = longint'(value[9:0]);
                REG_LOWER_LIMIT: lower_limit = longint'($signed(value[10:0]));
                REG_DRIVE_FLOOR: floor_level = longint'(value[9:0]);
                REG_DEADBAND:    band        = longint'(value[15:0]);
                REG_POS_OFFSET:  offset      = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction

        function void note_step(logic signed [31:0] tgt, logic signed [31:0] pos,
                                logic [31:0] now);
            localparam longint ERR_HIGH = 64'sd4294967295;
            localparam longint ERR_LOW  = -64'sd4294967296;
            localparam longint unsigned STEP_CAP = 64'd1 << 40;
            longint err, hi, lo, isum, diff, dterm, sum, drv;
            longint unsigned mag, prod, absdiff, dmag;
            logic [127:0] wide;
            logic [31:0] dt;
            drive_result_t res;

            err = longint'(tgt) + offset - longint'(pos);
            if (err > ERR_HIGH)
                err = ERR_HIGH;
            if (err < ERR_LOW)
                err = ERR_LOW;

            if (err > -band && err < band)
            begin
                res.drive       = '0;
                res.in_deadband = 1'b1;
                pending_drives.push_back(res);
                return;
            end

            dt = now - last_time;
            if (dt == 0)
                dt = 32'd1;
            hi = upper_limit * 65536;
            lo = lower_limit * 65536;

            mag  = (err < 0) ? longint'(-err) : longint'(err);
            prod = longint'(gain_i) * mag;
            if (prod > STEP_CAP)
                prod = STEP_CAP;
            wide = {64'd0, prod} * {96'd0, dt};
            prod = (wide > {64'd0, STEP_CAP}) ? STEP_CAP : wide[63:0];
            isum = integral + ((err < 0) ? -longint'(prod) : longint'(prod));
            if (isum > hi)
                isum = hi;
            else if (isum < lo)
                isum = lo;
            integral = isum;

            diff    = err - last_error;
            absdiff = (diff < 0) ? longint'(-diff) : longint'(diff);
            dmag    = (longint'(gain_d) * absdiff) / {32'd0, dt};
            dterm   = (diff < 0) ? -longint'(dmag) : longint'(dmag);

            sum = gain_p * err + isum - dterm;
            if (sum > 0)
            begin
                if (sum > hi)
                    sum = hi;
                drv = sum / 65536 + floor_level;
            end
            else
            begin
                if (sum < lo)
                    sum = lo;
                drv = sum / 65536 - floor_level;
            end

            last_error = err;
            last_time  = now;

            res.drive       = drv[11:0];
            res.in_deadband = 1'b0;
            pending_drives.push_back(res);
        endfunction

        function void check_result(logic signed [11:0] got_drive, logic got_band);
            drive_result_t want;
            if (pending_drives.size() == 0)
            begin
                $error("unexpected transfer: drive %0d in_deadband %0b", got_drive, got_band);
                failures++;
                return;
            end
            want = pending_drives.pop_front();
            if (got_drive !== want.drive)
            begin
                $error("drive: expected %0d, actual %0d", want.drive, got_drive);
                failures++;
            end
            if (got_band !== want.in_deadband)
            begin
                $error("in_deadband: expected %0b, actual %0b", want.in_deadband, got_band);
                failures++;
            end
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [4:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic signed [31:0] target      = '0;
    logic signed [31:0] position    = '0;
    logic [31:0]        now_ms      = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic signed [11:0] drive;
    logic               in_deadband;

    drive_scoreboard board;
    bit              quiet = 1'b0;
    int              cycle_count = 0;
    logic [31:0]     clock_ms = '0;

    pid_position_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .target      (target),
        .position    (position),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .in_deadband (in_deadband)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pid_position_controller regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(drive, in_deadband);
            out_stall <= !quiet && ($urandom_range(99) < 19);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input logic [31:0] up,
                                 input logic [31:0] lo, input logic [31:0] fl,
                                 input logic [31:0] db, input logic [31:0] off);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_UPPER_LIMIT, up);
        write_reg(REG_LOWER_LIMIT, lo);
        write_reg(REG_DRIVE_FLOOR, fl);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_POS_OFFSET, off);
    endtask

    // hold valid across consecutive transfers; drop it only for an idle gap
    task automatic send_step(input logic [31:0] tgt, input logic [31:0] pos,
                             input logic [31:0] now);
        if (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        target   <= tgt;
        position <= pos;
        now_ms   <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_step(tgt, pos, now);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'h00FF_FFFF;
            5:       return $urandom & 32'h00FF_FFFF;
            default: return $urandom_range(131072);
        endcase
    endfunction

    initial
    begin
        logic [31:0] gp, gi, gd, up, lo, fl, db, off, tgt, pos;
        int          delta, span, tier;

        board = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 32'd1023,
                      -32'sd1023, 32'd5, 32'd2, 32'd0);
        send_step(32'd0, 32'd0, 32'd0);
        send_step(32'd1, 32'd0, 32'd3);
        send_step(32'd2, 32'd0, 32'd10);
        send_step(-32'sd2, 32'd0, 32'd10);
        send_step(-32'sd1, 32'd0, 32'd12);
        send_step(32'd100, 32'd0, 32'd20);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'd30);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'd31);
        send_step(32'd500, 32'd20, 32'hFFFF_FFF0);
        send_step(-32'sd700, 32'd40, 32'h0000_0004);
        send_step(-32'sd700, 32'd40, 32'h0000_0004);
        settle();

        load_settings(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'd1023,
                      -32'sd1023, 32'd1023, 32'd0, 32'h7FFF_FFFF);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'd40);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'd40);
        send_step(32'd0, 32'h7FFF_FFFF, 32'd900);
        send_step(32'd0, 32'd0, 32'h8000_0000);
        settle();

        load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65535,
                      32'h8000_0000);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'd50);
        send_step(32'd0, 32'h8000_0000, 32'd51);
        send_step(32'd65534, 32'h8000_0000, 32'd52);
        send_step(-32'sd65534, 32'h8000_0000, 32'd53);
        send_step(32'd65535, 32'h8000_0000, 32'd54);
        send_step(-32'sd65535, 32'h8000_0000, 32'd60);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            quiet = (ph == QUIET_PHASE);
            if (ph == 0)
            begin
                gp = 32'h00FF_FFFF; gi = 32'h00FF_FFFF; gd = 32'h00FF_FFFF;
                up = 32'd1023; lo = -32'sd1023; fl = 32'd1023; db = 32'd65535;
                off = 32'h7FFF_FFFF;
            end
            else if (ph == 1)
            begin
                gp = 32'd0; gi = 32'd0; gd = 32'd0;
                up = 32'd0; lo = 32'd0; fl = 32'd0; db = 32'd0;
                off = 32'h8000_0000;
            end
            else
            begin
                gp = pick_gain();
                gi = pick_gain();
                gd = pick_gain();
                case ($urandom_range(3))
                    0:       up = 32'd0;
                    1:       up = 32'd1023;
                    default: up = $urandom_range(1023);
                endcase
                case ($urandom_range(3))
                    0:       lo = 32'd0;
                    1:       lo = -32'sd1023;
                    default: lo = -$urandom_range(1023);
                endcase
                case ($urandom_range(3))
                    0:       fl = 32'd0;
                    1:       fl = $urandom_range(1023);
                    default: fl = $urandom_range(50);
                endcase
                case ($urandom_range(4))
                    0:       db = 32'd0;
                    1:       db = $urandom_range(65535);
                    default: db = $urandom_range(20);
                endcase
                case ($urandom_range(5))
                    0:       off = 32'd0;
                    1:       off = $urandom;
                    2:       off = 32'h7FFF_FFFF;
                    3:       off = 32'h8000_0000;
                    default: off = $urandom_range(2000) - 1000;
                endcase
            end
            load_settings(gp, gi, gd, up, lo, fl, db, off);

            span = (db > 60000) ? 60004 : int'(db) + 4;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                tier = $urandom_range(99);
                if (tier < 30)
                    delta = int'($urandom_range(2 * span)) - span;
                else if (tier < 70)
                    delta = int'($urandom_range(4000)) - 2000;
                else
                    delta = int'($urandom_range(2097152)) - 1048576;
                if ($urandom_range(1) == 0)
                    pos = $urandom;
                else
                    pos = $urandom_range(200000) - 100000;
                if (tier >= 88)
                    tgt = $urandom;
                else
                    tgt = pos + delta - off;
                if ($urandom_range(19) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(20);
                send_step(tgt, pos, clock_ms);
            end
            settle();
        end
        quiet = 1'b0;

        repeat (120)
            @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d drive transfers never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0)
            $display("pid_position_controller regression: pass");
        else
            $display("pid_position_controller regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
